>>> design/gsv_pkg.sv
package gsv_pkg;

	// Grid geometry, fixed by the packing of the configuration words
	localparam int DIMS       = 4;
	localparam int CNT_W      = 8;
	localparam int VAL_W      = 16;
	localparam int ORD_W      = 2;
	localparam int DIM_W      = 3;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 64;

	// Datapath widths: |to - from| fits VAL_W bits, product of index and span
	localparam int PROD_W  = CNT_W + VAL_W;
	localparam int SUM_W   = PROD_W + 2;
	localparam int DIV_CYC = PROD_W / 2;
	localparam int DIVC_W  = $clog2(DIV_CYC + 1);

	localparam logic signed [SUM_W-1:0] SAT_HI = SUM_W'((1 << (VAL_W - 1)) - 1);
	localparam logic signed [SUM_W-1:0] SAT_LO = -SAT_HI - SUM_W'(1);

	// Register indexes
	localparam logic [CFG_IDX_W-1:0] REG_START  = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_END    = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_COUNTS = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_ORDER  = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_DIMS   = 3'd4;

	// Register reset values
	localparam logic [DIMS*CNT_W-1:0] RST_COUNTS = 32'h0101_0101;
	localparam logic [DIMS*ORD_W-1:0] RST_ORDER  = 8'hE4;
	localparam logic [DIM_W-1:0]      RST_DIMS   = 3'd4;

	typedef struct packed {
		logic [DIMS*VAL_W-1:0] start_v;
		logic [DIMS*VAL_W-1:0] end_v;
		logic [DIMS*CNT_W-1:0] counts;
		logic [DIMS*ORD_W-1:0] order;
		logic [DIM_W-1:0]      dims;
	} cfg_t;

	// Controller to datapath
	typedef struct packed {
		logic             take;
		logic             check;
		logic             mul;
		logic             fin;
		logic             step;
		logic             load_out;
		logic [ORD_W-1:0] k;
	} cmd_t;

	// Datapath to controller
	typedef struct packed {
		logic bad;
		logic early;
		logic div_busy;
		logic k_last;
		logic out_free;
	} stat_t;

	function automatic logic [CNT_W-1:0] count_of(input logic [DIMS*CNT_W-1:0] w,
		input logic [ORD_W-1:0] k);
		return w[k*CNT_W +: CNT_W];
	endfunction

	function automatic logic [VAL_W-1:0] val_of(input logic [DIMS*VAL_W-1:0] w,
		input logic [ORD_W-1:0] k);
		return w[k*VAL_W +: VAL_W];
	endfunction

	function automatic logic [ORD_W-1:0] order_of(input logic [DIMS*ORD_W-1:0] w,
		input logic [ORD_W-1:0] j);
		return w[j*ORD_W +: ORD_W];
	endfunction

endpackage

>>> design/grid_sweep_vector_generator_core.sv
// Channel   Handshake              Payload
// cfg       cfg_valid / cfg_ready  cfg_index, cfg_data (ready is always high)
// req       req_valid / req_stall  restart
// res       res_valid / res_stall  coord_0..coord_3, point_valid, last_point,
//                                  sweep_done, order_error
//
// An item that yields a point runs each coordinate in turn through the
// shared serial divider, two quotient bits per cycle over a 24-bit dividend;
// an item that yields only a flag skips the divider.
// Reset clears the counters and loads the register reset values.
// A stalled result sits in the output register; the next item is taken
// and worked on meanwhile, and waits only to be written out.
module grid_sweep_vector_generator_core import gsv_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	input  logic                  req_valid,
	output logic                  req_stall,
	input  logic                  restart,
	output logic                  res_valid,
	input  logic                  res_stall,
	output logic signed [VAL_W-1:0] coord_0,
	output logic signed [VAL_W-1:0] coord_1,
	output logic signed [VAL_W-1:0] coord_2,
	output logic signed [VAL_W-1:0] coord_3,
	output logic                  point_valid,
	output logic                  last_point,
	output logic                  sweep_done,
	output logic                  order_error
);

	cfg_t                       cfg;
	cmd_t                       cmd;
	stat_t                      status;
	logic [DIMS-1:0][VAL_W-1:0] coord;

	assign cfg_ready = 1'b1;

	gsv_cfg u_cfg (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (cfg_valid && cfg_ready),
		.wr_index (cfg_index),
		.wr_data  (cfg_data),
		.cfg      (cfg)
	);

	gsv_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.status    (status),
		.cmd       (cmd)
	);

	gsv_dpath u_dpath (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg),
		.cmd       (cmd),
		.restart   (restart),
		.res_stall (res_stall),
		.status    (status),
		.res_valid (res_valid),
		.res_coord (coord),
		.res_point (point_valid),
		.res_last  (last_point),
		.res_done  (sweep_done),
		.res_err   (order_error)
	);

	assign coord_0 = signed'(coord[0]);
	assign coord_1 = signed'(coord[1]);
	assign coord_2 = signed'(coord[2]);
	assign coord_3 = signed'(coord[3]);

endmodule

>>> design/gsv_cfg.sv
module gsv_cfg import gsv_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  wr_en,
	input  logic [CFG_IDX_W-1:0]  wr_index,
	input  logic [CFG_DATA_W-1:0] wr_data,
	output cfg_t                  cfg
);

	cfg_t cfg_q;

	// Register file; writes beyond the list are dropped
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.start_v <= '0;
			cfg_q.end_v   <= '0;
			cfg_q.counts  <= RST_COUNTS;
			cfg_q.order   <= RST_ORDER;
			cfg_q.dims    <= RST_DIMS;
		end else if (wr_en) begin
			case (wr_index)
				REG_START:  cfg_q.start_v <= wr_data[DIMS*VAL_W-1:0];
				REG_END:    cfg_q.end_v   <= wr_data[DIMS*VAL_W-1:0];
				REG_COUNTS: cfg_q.counts  <= wr_data[DIMS*CNT_W-1:0];
				REG_ORDER:  cfg_q.order   <= wr_data[DIMS*ORD_W-1:0];
				REG_DIMS:   cfg_q.dims    <= wr_data[DIM_W-1:0];
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

>>> design/gsv_div.sv
module gsv_div import gsv_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  logic [PROD_W-1:0] dividend,
	input  logic [CNT_W-1:0]  divisor,
	output logic [PROD_W-1:0] quotient,
	output logic              busy
);

	logic [PROD_W-1:0] quo_q;
	logic [CNT_W-1:0]  rem_q;
	logic [CNT_W-1:0]  dsr_q;
	logic [DIVC_W-1:0] cyc_q;

	logic [CNT_W+PROD_W-1:0] st1, st2;

	// One restoring step: shift in the next dividend bit, subtract if it fits
	function automatic logic [CNT_W+PROD_W-1:0] div_step(input logic [CNT_W-1:0] rem,
		input logic [PROD_W-1:0] quo, input logic [CNT_W-1:0] dsr);
		logic [CNT_W:0] sh;
		logic [CNT_W:0] diff;
		sh   = {rem, quo[PROD_W-1]};
		diff = sh - {1'b0, dsr};
		if (sh >= {1'b0, dsr})
			return {diff[CNT_W-1:0], quo[PROD_W-2:0], 1'b1};
		else
			return {sh[CNT_W-1:0], quo[PROD_W-2:0], 1'b0};
	endfunction

	// Two quotient bits per cycle
	always_comb begin
		st1 = div_step(rem_q, quo_q, dsr_q);
		st2 = div_step(st1[CNT_W+PROD_W-1:PROD_W], st1[PROD_W-1:0], dsr_q);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cyc_q <= '0;
		end else if (start) begin
			cyc_q <= DIVC_W'(DIV_CYC);
		end else if (cyc_q != '0) begin
			cyc_q <= cyc_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= dividend;
			rem_q <= '0;
			dsr_q <= divisor;
		end else if (cyc_q != '0) begin
			rem_q <= st2[CNT_W+PROD_W-1:PROD_W];
			quo_q <= st2[PROD_W-1:0];
		end
	end

	assign quotient = quo_q;
	assign busy     = (cyc_q != '0);

endmodule

>>> design/gsv_dpath.sv
module gsv_dpath import gsv_pkg::*; (
	input  logic                       clk,
	input  logic                       arst_n,
	input  cfg_t                       cfg,
	input  cmd_t                       cmd,
	input  logic                       restart,
	input  logic                       res_stall,
	output stat_t                      status,
	output logic                       res_valid,
	output logic [DIMS-1:0][VAL_W-1:0] res_coord,
	output logic                       res_point,
	output logic                       res_last,
	output logic                       res_done,
	output logic                       res_err
);

	// Sweep state
	logic [DIMS-1:0][CNT_W-1:0] cnt_q;
	logic                       exh_q;

	// Working result
	logic [DIMS-1:0][VAL_W-1:0] crd_q;
	logic                       pv_q, lp_q, sd_q, oe_q;
	logic                       neg_q;

	// Output register
	logic                       res_valid_q;
	logic [DIMS-1:0][VAL_W-1:0] res_coord_q;
	logic                       res_point_q, res_last_q, res_done_q, res_err_q;

	logic [ORD_W-1:0] ck;
	logic [DIM_W-1:0] d_m1;
	logic [ORD_W-1:0] outer;
	logic [DIMS-1:0]  seen;
	logic             bad, zero, early;
	logic [ORD_W-1:0] o;

	logic [DIMS-1:0][CNT_W-1:0] nxt;
	logic                       carry;
	logic [CNT_W-1:0]           inc;
	logic                       last_hit;

	logic signed [VAL_W-1:0] from_v, to_v;
	logic        [VAL_W:0]   diff, mag_w;
	logic        [CNT_W-1:0] count_k;
	logic        [PROD_W-1:0] prod;
	logic        [PROD_W-1:0] div_q;
	logic                     div_busy;
	logic signed [SUM_W-1:0] qe, sum;
	logic        [VAL_W-1:0] coord_val;

	assign ck    = cmd.k;
	assign d_m1  = cfg.dims - 1'b1;
	assign outer = order_of(cfg.order, d_m1[ORD_W-1:0]);

	// Order check, zero count and end-of-sweep test
	always_comb begin
		seen = '0;
		bad  = (cfg.dims == '0) || (int'(cfg.dims) > DIMS);
		zero = 1'b0;
		o    = '0;
		for (int j = 0; j < DIMS; j++) begin
			if (j < int'(cfg.dims)) begin
				o = order_of(cfg.order, ORD_W'(j));
				if (int'(o) >= int'(cfg.dims) || seen[o])
					bad = 1'b1;
				else
					seen[o] = 1'b1;
				if (count_of(cfg.counts, ORD_W'(j)) == '0)
					zero = 1'b1;
			end
		end
		early = zero || exh_q || (cnt_q[outer] >= count_of(cfg.counts, outer));
	end

	// Counter advance with carry ripple along the nest order
	always_comb begin
		nxt   = cnt_q;
		carry = 1'b1;
		inc   = '0;
		for (int j = 0; j < DIMS; j++) begin
			if (j < int'(cfg.dims)) begin
				inc = nxt[order_of(cfg.order, ORD_W'(j))] + CNT_W'(carry);
				if (j < int'(cfg.dims) - 1 &&
					inc >= count_of(cfg.counts, order_of(cfg.order, ORD_W'(j)))) begin
					nxt[order_of(cfg.order, ORD_W'(j))] = '0;
					carry = 1'b1;
				end else begin
					nxt[order_of(cfg.order, ORD_W'(j))] = inc;
					carry = 1'b0;
				end
			end
		end
		last_hit = (nxt[outer] >= count_of(cfg.counts, outer));
	end

	// Span magnitude times index, feeds the divider
	always_comb begin
		from_v  = signed'(val_of(cfg.start_v, ck));
		to_v    = signed'(val_of(cfg.end_v, ck));
		count_k = count_of(cfg.counts, ck);
		diff    = {to_v[VAL_W-1], to_v} - {from_v[VAL_W-1], from_v};
		mag_w   = diff[VAL_W] ? (~diff + 1'b1) : diff;
		prod    = PROD_W'(cnt_q[ck]) * PROD_W'(mag_w[VAL_W-1:0]);
	end

	gsv_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (cmd.mul),
		.dividend (prod),
		.divisor  (count_k - 1'b1),
		.quotient (div_q),
		.busy     (div_busy)
	);

	// Signed quotient added to start, saturated
	always_comb begin
		qe  = signed'(SUM_W'(div_q));
		sum = SUM_W'(from_v) + (neg_q ? -qe : qe);
		if (count_k <= CNT_W'(1))
			coord_val = from_v;
		else if (sum > SAT_HI)
			coord_val = SAT_HI[VAL_W-1:0];
		else if (sum < SAT_LO)
			coord_val = SAT_LO[VAL_W-1:0];
		else
			coord_val = sum[VAL_W-1:0];
	end

	// Counters, exhausted flag and output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q       <= '0;
			exh_q       <= 1'b0;
			res_valid_q <= 1'b0;
		end else begin
			if (cmd.take && restart) begin
				cnt_q <= '0;
				exh_q <= 1'b0;
			end
			if (cmd.check && !bad && early)
				exh_q <= 1'b1;
			if (cmd.step) begin
				cnt_q <= nxt;
				if (last_hit)
					exh_q <= 1'b1;
			end
			if (cmd.load_out)
				res_valid_q <= 1'b1;
			else if (!res_stall)
				res_valid_q <= 1'b0;
		end
	end

	// Working result and output payload
	always_ff @(posedge clk) begin
		if (cmd.check) begin
			crd_q <= '0;
			pv_q  <= 1'b0;
			lp_q  <= 1'b0;
			sd_q  <= !bad && early;
			oe_q  <= bad;
		end
		if (cmd.mul)
			neg_q <= diff[VAL_W];
		if (cmd.fin)
			crd_q[ck] <= coord_val;
		if (cmd.step) begin
			pv_q <= 1'b1;
			if (last_hit) begin
				lp_q <= 1'b1;
				sd_q <= 1'b1;
			end
		end
		if (cmd.load_out) begin
			res_coord_q <= crd_q;
			res_point_q <= pv_q;
			res_last_q  <= lp_q;
			res_done_q  <= sd_q;
			res_err_q   <= oe_q;
		end
	end

	assign status.bad      = bad;
	assign status.early    = early;
	assign status.div_busy = div_busy;
	assign status.k_last   = (ck == d_m1[ORD_W-1:0]);
	assign status.out_free = !res_valid_q || !res_stall;

	assign res_valid = res_valid_q;
	assign res_coord = res_coord_q;
	assign res_point = res_point_q;
	assign res_last  = res_last_q;
	assign res_done  = res_done_q;
	assign res_err   = res_err_q;

endmodule

>>> design/gsv_ctrl.sv
module gsv_ctrl import gsv_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  req_valid,
	output logic  req_stall,
	input  stat_t status,
	output cmd_t  cmd
);

	localparam logic [2:0] S_IDLE  = 3'd0;
	localparam logic [2:0] S_CHECK = 3'd1;
	localparam logic [2:0] S_MUL   = 3'd2;
	localparam logic [2:0] S_DIV   = 3'd3;
	localparam logic [2:0] S_FIN   = 3'd4;
	localparam logic [2:0] S_STEP  = 3'd5;
	localparam logic [2:0] S_OUT   = 3'd6;

	logic [2:0]       state_q, state_d;
	logic [ORD_W-1:0] k_q, k_d;

	// Next state
	always_comb begin
		state_d = state_q;
		k_d     = k_q;
		case (state_q)
			S_IDLE: begin
				if (req_valid)
					state_d = S_CHECK;
			end
			S_CHECK: begin
				k_d = '0;
				if (status.bad || status.early)
					state_d = S_OUT;
				else
					state_d = S_MUL;
			end
			S_MUL: state_d = S_DIV;
			S_DIV: begin
				if (!status.div_busy)
					state_d = S_FIN;
			end
			S_FIN: begin
				if (status.k_last) begin
					state_d = S_STEP;
				end else begin
					k_d     = k_q + 1'b1;
					state_d = S_MUL;
				end
			end
			S_STEP: state_d = S_OUT;
			S_OUT: begin
				if (status.out_free)
					state_d = S_IDLE;
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			k_q     <= '0;
		end else begin
			state_q <= state_d;
			k_q     <= k_d;
		end
	end

	// Commands
	assign req_stall    = (state_q != S_IDLE);
	assign cmd.take     = req_valid && (state_q == S_IDLE);
	assign cmd.check    = (state_q == S_CHECK);
	assign cmd.mul      = (state_q == S_MUL);
	assign cmd.fin      = (state_q == S_FIN);
	assign cmd.step     = (state_q == S_STEP);
	assign cmd.load_out = (state_q == S_OUT) && status.out_free;
	assign cmd.k        = k_q;

endmodule

>>> design/gsv_checker.sv
module gsv_checker import gsv_pkg::*; (
	input logic                    clk,
	input logic                    arst_n,
	input logic                    res_valid,
	input logic                    res_stall,
	input logic signed [VAL_W-1:0] coord_0,
	input logic signed [VAL_W-1:0] coord_1,
	input logic signed [VAL_W-1:0] coord_2,
	input logic signed [VAL_W-1:0] coord_3,
	input logic                    point_valid,
	input logic                    last_point,
	input logic                    sweep_done,
	input logic                    order_error
);

	// A stalled item stays offered
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res_stall |=> res_valid)
		else $error("result dropped while stalled");

	// The final point closes the sweep
	a_last: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && last_point |-> point_valid && sweep_done)
		else $error("last point without point or done");

	// A bad order yields neither a point nor an end of sweep
	a_err: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && order_error |-> !point_valid && !sweep_done && !last_point)
		else $error("order error mixed with sweep flags");

	// No point means all coordinates are zero
	a_zero: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !point_valid |->
			coord_0 == '0 && coord_1 == '0 && coord_2 == '0 && coord_3 == '0)
		else $error("coordinates set without a point");

endmodule

bind grid_sweep_vector_generator_core gsv_checker u_gsv_checker (.*);

>>> tb/sv/grid_sweep_vector_generator_core_test.sv
module grid_sweep_vector_generator_core_test;
	timeunit 1ns;
	timeprecision 1ps;

	import gsv_pkg::*;

	localparam int HOLD_CYCLES  = 300;
	localparam int RANDOM_ITEMS = 420;
	localparam int TAIL_CYCLES  = 80;
	localparam int PRINT_CAP    = 40;

	// Indexes past the last register; writes there must change nothing
	localparam logic [CFG_IDX_W-1:0] UNMAPPED_REG_FIRST = REG_DIMS + 3'd1;

	typedef struct packed {
		logic [DIMS*VAL_W-1:0] coords;
		logic                  point_valid;
		logic                  last_point;
		logic                  sweep_done;
		logic                  order_error;
	} grid_point_t;

	typedef enum logic {ROW_CFG, ROW_REQ} row_kind_t;

	typedef struct packed {
		row_kind_t             kind;
		logic [CFG_IDX_W-1:0]  idx;
		logic [CFG_DATA_W-1:0] data;
		logic                  rst;
		logic                  typed;
		grid_point_t           want;
	} plan_row_t;

	logic                  clk;
	logic                  arst_n;
	logic                  cfg_valid;
	logic                  cfg_ready;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;
	logic                  req_valid;
	logic                  req_stall;
	logic                  restart;
	logic                  res_valid;
	logic                  res_stall;
	logic signed [VAL_W-1:0] coord_0;
	logic signed [VAL_W-1:0] coord_1;
	logic signed [VAL_W-1:0] coord_2;
	logic signed [VAL_W-1:0] coord_3;
	logic                  point_valid;
	logic                  last_point;
	logic                  sweep_done;
	logic                  order_error;

	// Mirror of the registers and the sweep state
	cfg_t             grid_cfg;
	logic [CNT_W-1:0] idx_cnt [DIMS];
	bit               sweep_over;

	grid_point_t pending_points [$];
	plan_row_t   plan [$];

	int  mismatches;
	int  items_sent;
	int  setups_loaded;
	int  points_seen;
	int  last_seen;
	int  done_only_seen;
	int  errors_seen;
	bit  hold_ask;
	bit  calm;

	grid_sweep_vector_generator_core DUT (.*);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	initial begin
		#2_000_000;
		$display("grid_sweep_vector_generator_core_test: done, errors");
		$finish;
	end

	function automatic grid_point_t pt(input logic [DIMS*VAL_W-1:0] c, input bit pv,
		input bit lst, input bit dn, input bit err);
		grid_point_t p;
		p.coords      = c;
		p.point_valid = pv;
		p.last_point  = lst;
		p.sweep_done  = dn;
		p.order_error = err;
		return p;
	endfunction

	// Serves one request: returns the reply and advances the sweep
	function automatic grid_point_t next_grid_point(input bit rst);
		grid_point_t      p;
		int               d, j, k, o, outer, first, a, b;
		int               from_v, to_v, cnt, r;
		logic [DIMS-1:0]  seen;
		bit               bad, zero;
		p = '0;
		if (rst) begin
			for (k = 0; k < DIMS; k++) idx_cnt[k] = '0;
			sweep_over = 1'b0;
		end
		d = int'(grid_cfg.dims);
		bad = (d == 0 || d > DIMS);
		seen = '0;
		if (!bad) begin
			for (j = 0; j < d; j++) begin
				o = int'(grid_cfg.order[j*ORD_W +: ORD_W]);
				if (o >= d || seen[o]) bad = 1'b1;
				else seen[o] = 1'b1;
			end
		end
		if (bad) begin
			p.order_error = 1'b1;
			return p;
		end
		zero = 1'b0;
		for (k = 0; k < d; k++)
			if (grid_cfg.counts[k*CNT_W +: CNT_W] == '0) zero = 1'b1;
		outer = int'(grid_cfg.order[(d-1)*ORD_W +: ORD_W]);
		if (zero || sweep_over || idx_cnt[outer] >= grid_cfg.counts[outer*CNT_W +: CNT_W]) begin
			sweep_over = 1'b1;
			p.sweep_done = 1'b1;
			return p;
		end
		// Coordinates, saturated when a counter runs past its count
		for (k = 0; k < d; k++) begin
			from_v = int'($signed(grid_cfg.start_v[k*VAL_W +: VAL_W]));
			to_v   = int'($signed(grid_cfg.end_v[k*VAL_W +: VAL_W]));
			cnt    = int'(grid_cfg.counts[k*CNT_W +: CNT_W]);
			if (cnt <= 1) r = from_v;
			else r = from_v + (int'(idx_cnt[k]) * (to_v - from_v)) / (cnt - 1);
			if (r < -32768) r = -32768;
			if (r > 32767) r = 32767;
			p.coords[k*VAL_W +: VAL_W] = r[VAL_W-1:0];
		end
		p.point_valid = 1'b1;
		// Step the innermost counter and ripple carries outward
		first = int'(grid_cfg.order[ORD_W-1:0]);
		idx_cnt[first] = idx_cnt[first] + 1'b1;
		for (j = 0; j + 1 < d; j++) begin
			a = int'(grid_cfg.order[j*ORD_W +: ORD_W]);
			b = int'(grid_cfg.order[(j+1)*ORD_W +: ORD_W]);
			if (idx_cnt[a] >= grid_cfg.counts[a*CNT_W +: CNT_W]) begin
				idx_cnt[a] = '0;
				idx_cnt[b] = idx_cnt[b] + 1'b1;
			end
		end
		if (idx_cnt[outer] >= grid_cfg.counts[outer*CNT_W +: CNT_W]) begin
			sweep_over = 1'b1;
			p.last_point = 1'b1;
			p.sweep_done = 1'b1;
		end
		return p;
	endfunction

	task automatic note_mismatch(input string what, input logic [63:0] got,
		input logic [63:0] want);
		if (mismatches < PRINT_CAP)
			$display("ERROR t=%0t %s: got %h want %h", $realtime, what, got, want);
		mismatches++;
	endtask

	// Register write; also updates the mirror
	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
		bit taken;
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		taken = 1'b0;
		while (!taken) begin
			@(negedge clk);
			taken = cfg_ready;
			@(posedge clk);
		end
		case (idx)
			REG_START:  grid_cfg.start_v = data[DIMS*VAL_W-1:0];
			REG_END:    grid_cfg.end_v   = data[DIMS*VAL_W-1:0];
			REG_COUNTS: grid_cfg.counts  = data[DIMS*CNT_W-1:0];
			REG_ORDER:  grid_cfg.order   = data[DIMS*ORD_W-1:0];
			REG_DIMS:   grid_cfg.dims    = data[DIM_W-1:0];
			default: ;
		endcase
		cfg_valid <= 1'b0;
		@(posedge clk);
	endtask

	// Offer one request; the expected reply is queued once it is taken
	task automatic offer_item(input bit rst, input bit typed, input grid_point_t want);
		int          gap;
		bit          taken;
		grid_point_t p;
		gap = calm ? 0 : $urandom_range(0, 9);
		if (gap != 0) begin
			req_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		req_valid <= 1'b1;
		restart   <= rst;
		taken = 1'b0;
		while (!taken) begin
			@(negedge clk);
			taken = !req_stall;
			@(posedge clk);
		end
		p = next_grid_point(rst);
		pending_points.insert(pending_points.size(), typed ? want : p);
		items_sent++;
	endtask

	// Stop offering and wait for every outstanding reply
	task automatic drain_results();
		req_valid <= 1'b0;
		while (pending_points.size() != 0) @(posedge clk);
		@(posedge clk);
	endtask

	function automatic logic [VAL_W-1:0] pick_q88();
		case ($urandom_range(0, 9))
			0: return 16'h8000;
			1: return 16'h7FFF;
			2: return '0;
			default: return VAL_W'($urandom);
		endcase
	endfunction

	function automatic logic [CNT_W-1:0] pick_count();
		case ($urandom_range(0, 19))
			0: return '0;
			1: return '1;
			2, 3, 4: return CNT_W'($urandom_range(5, 16));
			default: return CNT_W'($urandom_range(1, 4));
		endcase
	endfunction

	// Random geometry, mostly a legal nesting order
	task automatic load_random_setup();
		cfg_t             s;
		logic [ORD_W-1:0] perm [DIMS];
		logic [ORD_W-1:0] sw;
		int               d, j, t;
		d = $urandom_range(1, DIMS);
		if ($urandom_range(0, 9) == 0)
			d = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(DIMS + 1, 7);
		s.dims  = d[DIM_W-1:0];
		s.order = (ORD_W*DIMS)'($urandom);
		if ($urandom_range(0, 9) != 0 && d >= 1 && d <= DIMS) begin
			for (j = 0; j < DIMS; j++) perm[j] = j[ORD_W-1:0];
			for (j = d - 1; j > 0; j--) begin
				t = $urandom_range(0, j);
				sw = perm[j];
				perm[j] = perm[t];
				perm[t] = sw;
			end
			for (j = 0; j < d; j++) s.order[j*ORD_W +: ORD_W] = perm[j];
		end
		for (j = 0; j < DIMS; j++) begin
			s.start_v[j*VAL_W +: VAL_W] = pick_q88();
			s.end_v[j*VAL_W +: VAL_W]   = pick_q88();
			s.counts[j*CNT_W +: CNT_W]  = pick_count();
		end
		write_reg(REG_START, s.start_v);
		write_reg(REG_END, s.end_v);
		write_reg(REG_COUNTS, {32'($urandom), s.counts});
		write_reg(REG_ORDER, {32'($urandom), 24'($urandom), s.order});
		write_reg(REG_DIMS, {32'($urandom), 29'($urandom), s.dims});
		if ($urandom_range(0, 4) == 0)
			write_reg(UNMAPPED_REG_FIRST + CFG_IDX_W'($urandom_range(0, 2)),
				{32'($urandom), 32'($urandom)});
		setups_loaded++;
	endtask

	function automatic void plan_cfg(input logic [CFG_IDX_W-1:0] idx,
		input logic [CFG_DATA_W-1:0] data);
		plan_row_t r;
		r = '0;
		r.kind = ROW_CFG;
		r.idx  = idx;
		r.data = data;
		plan.insert(plan.size(), r);
	endfunction

	function automatic void plan_req(input bit rst, input bit typed, input grid_point_t want);
		plan_row_t r;
		r = '0;
		r.kind  = ROW_REQ;
		r.rst   = rst;
		r.typed = typed;
		r.want  = want;
		plan.insert(plan.size(), r);
	endfunction

	// Result side: random stalls, one long hold on request
	initial begin : drain_side
		int          n;
		bit          got;
		grid_point_t g, w;
		int          k;
		res_stall <= 1'b0;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			n = calm ? 0 : $urandom_range(0, 9);
			if (n != 0) begin
				res_stall <= 1'b1;
				repeat (n) @(posedge clk);
				res_stall <= 1'b0;
			end
			got = 1'b0;
			while (!got) begin
				@(negedge clk);
				if (res_valid && !res_stall) begin
					g.coords      = {coord_3, coord_2, coord_1, coord_0};
					g.point_valid = point_valid;
					g.last_point  = last_point;
					g.sweep_done  = sweep_done;
					g.order_error = order_error;
					got = 1'b1;
				end
				@(posedge clk);
				if (!got && hold_ask) begin
					hold_ask = 1'b0;
					res_stall <= 1'b1;
					repeat (HOLD_CYCLES) @(posedge clk);
					res_stall <= 1'b0;
				end
			end
			// Compare against the oldest expected reply
			if (pending_points.size() == 0) begin
				note_mismatch("reply with nothing expected", g.coords, '0);
			end else begin
				w = pending_points.pop_front();
				for (k = 0; k < DIMS; k++)
					if (g.coords[k*VAL_W +: VAL_W] !== w.coords[k*VAL_W +: VAL_W])
						note_mismatch($sformatf("coord_%0d", k),
							64'(g.coords[k*VAL_W +: VAL_W]),
							64'(w.coords[k*VAL_W +: VAL_W]));
				if (g.point_valid !== w.point_valid)
					note_mismatch("point_valid", 64'(g.point_valid), 64'(w.point_valid));
				if (g.last_point !== w.last_point)
					note_mismatch("last_point", 64'(g.last_point), 64'(w.last_point));
				if (g.sweep_done !== w.sweep_done)
					note_mismatch("sweep_done", 64'(g.sweep_done), 64'(w.sweep_done));
				if (g.order_error !== w.order_error)
					note_mismatch("order_error", 64'(g.order_error), 64'(w.order_error));
			end
			if (g.point_valid) points_seen++;
			if (g.last_point) last_seen++;
			if (!g.point_valid && g.sweep_done) done_only_seen++;
			if (g.order_error) errors_seen++;
		end
	end

	// Request side and configuration
	initial begin : feed_side
		grid_point_t done_only, err_only;
		bit          in_cfg;
		int          phase, n, i, target;
		arst_n    <= 1'b0;
		cfg_valid <= 1'b0;
		cfg_index <= '0;
		cfg_data  <= '0;
		req_valid <= 1'b0;
		restart   <= 1'b0;
		hold_ask = 1'b0;
		calm = 1'b0;
		grid_cfg = '{start_v: '0, end_v: '0, counts: RST_COUNTS, order: RST_ORDER,
			dims: RST_DIMS};
		for (i = 0; i < DIMS; i++) idx_cnt[i] = '0;
		sweep_over = 1'b0;

		done_only = pt('0, 0, 0, 1, 0);
		err_only  = pt('0, 0, 0, 0, 1);

		// Reset geometry: one point at the origin, then nothing left
		plan_req(0, 1, pt('0, 1, 1, 1, 0));
		plan_req(0, 1, done_only);
		plan_req(1, 1, pt('0, 1, 1, 1, 0));
		// Full-range spans, 3 x 2 grid
		plan_cfg(REG_START, 64'hFF00_0100_7FFF_8000);
		plan_cfg(REG_END, 64'h0000_0100_8000_7FFF);
		plan_cfg(REG_COUNTS, 64'h0101_0203);
		plan_cfg(REG_ORDER, 64'hE4);
		plan_cfg(REG_DIMS, 64'd4);
		plan_req(1, 1, pt(64'hFF00_0100_7FFF_8000, 1, 0, 0, 0));
		repeat (5) plan_req(0, 0, '0);
		plan_req(0, 1, done_only);
		// A zero count ends the sweep at once
		plan_cfg(REG_COUNTS, 64'h0100_0203);
		plan_req(1, 1, done_only);
		// Repeated dimension in the order
		plan_cfg(REG_ORDER, 64'h00);
		plan_req(1, 1, err_only);
		// One dimension: entries above it are ignored
		plan_cfg(REG_DIMS, 64'd1);
		plan_req(1, 1, pt(64'h0000_0000_0000_8000, 1, 0, 0, 0));
		plan_req(0, 0, '0);
		plan_req(0, 0, '0);
		// Dimension count out of range
		plan_cfg(REG_DIMS, 64'd0);
		plan_req(0, 1, err_only);
		plan_cfg(REG_DIMS, 64'd7);
		plan_req(0, 1, err_only);
		// Reversed nesting, long outer dimension
		plan_cfg(REG_ORDER, 64'h1B);
		plan_cfg(REG_DIMS, 64'd4);
		plan_cfg(REG_COUNTS, 64'h0301_01FF);
		plan_cfg(REG_START, 64'h8000_0100_7FFF_8000);
		plan_cfg(REG_END, 64'h7FFF_0100_8000_7FFF);
		plan_req(1, 0, '0);
		plan_req(0, 0, '0);
		// Inner count lowered under its counter: coordinate saturates
		plan_cfg(REG_COUNTS, 64'h0201_01FF);
		plan_req(0, 0, '0);
		// Outer counter already at its count
		plan_cfg(REG_COUNTS, 64'h0201_0101);
		plan_req(0, 1, done_only);
		// Raising the count again does not revive the sweep
		plan_cfg(REG_COUNTS, 64'h0201_01FF);
		plan_req(0, 1, done_only);

		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed walk
		in_cfg = 1'b0;
		foreach (plan[r]) begin
			if (plan[r].kind == ROW_CFG) begin
				if (!in_cfg) drain_results();
				write_reg(plan[r].idx, plan[r].data);
				in_cfg = 1'b1;
			end else begin
				offer_item(plan[r].rst, plan[r].typed, plan[r].want);
				in_cfg = 1'b0;
			end
		end

		// Random phases, each with its own geometry
		target = items_sent + RANDOM_ITEMS;
		phase = 0;
		while (items_sent < target) begin
			drain_results();
			load_random_setup();
			calm = (phase % 5 == 3);
			if (phase == 2) hold_ask = 1'b1;
			n = $urandom_range(15, 45);
			for (i = 0; i < n; i++) begin
				if (i == 0) offer_item($urandom_range(0, 3) != 0, 0, '0);
				else offer_item($urandom_range(0, 15) == 0, 0, '0);
				// Occasionally let the block run dry mid phase
				if ($urandom_range(0, 39) == 0) drain_results();
			end
			phase++;
		end

		drain_results();
		repeat (TAIL_CYCLES) @(posedge clk);
		$display("Covered %0d requests over %0d random setups: %0d points, %0d sweep ends,",
			items_sent, setups_loaded, points_seen, last_seen);
		$display("  %0d done-only replies, %0d order errors, %0d mismatches",
			done_only_seen, errors_seen, mismatches);
		if (mismatches == 0)
			$display("grid_sweep_vector_generator_core_test: done, clean");
		else
			$display("grid_sweep_vector_generator_core_test: done, errors");
		$finish;
	end

endmodule
